// ===== rtl/modem_escape_guard_detector_top_assert.svh =====
// Assertion macros for the escape guard detector checkers.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef MODEM_ESCAPE_GUARD_DETECTOR_TOP_ASSERT_SVH
`define MODEM_ESCAPE_GUARD_DETECTOR_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define MEGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define MEGD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/megd_pkg.sv =====
package megd_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_TERM     = 2'd1;
  localparam logic [1:0] FUNC_MODEM    = 2'd2;
  localparam logic [1:0] FUNC_RETURN   = 2'd3;

  // Result destinations
  localparam logic [1:0] DEST_MODEM    = 2'd0;
  localparam logic [1:0] DEST_TERM     = 2'd1;
  localparam logic [1:0] DEST_CLI      = 2'd2;

  localparam logic [7:0] PLUS_CHAR     = 8'h2B;

  // Guard time scaling
  localparam int unsigned US_PER_UNIT  = 20000;
  localparam int unsigned GUARD_UNITS_RESET = 50;
  localparam int unsigned GUARD_W      = 23;
  localparam logic [GUARD_W-1:0] GUARD_RESET_US = GUARD_W'(GUARD_UNITS_RESET * US_PER_UNIT);
  localparam logic [GUARD_W-1:0] US_PER_UNIT_C  = GUARD_W'(US_PER_UNIT);

  localparam int unsigned TIMER_W      = 24;

  // Job queue between front and back
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned PTR_W        = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W        = $clog2(FIFO_DEPTH + 1);

  // Result counting within one job
  localparam int unsigned IDX_W        = 4;

  typedef enum logic [1:0] {
    MSG_NONE,
    MSG_BYTE,
    MSG_OK,
    MSG_CONNECT
  } msg_e;

  // One job: replay plus_cnt '+' to the modem side, then the message
  typedef struct packed {
    logic [1:0] plus_cnt;
    msg_e       msg;
    logic [1:0] dest;
    logic [7:0] data;
  } job_t;

  function automatic logic [IDX_W-1:0] msg_len(msg_e m);
    logic [IDX_W-1:0] len;
    case (m)
      MSG_BYTE:    len = IDX_W'(1);
      MSG_OK:      len = IDX_W'(4);
      MSG_CONNECT: len = IDX_W'(9);
      default:     len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] ok_char(logic [1:0] j);
    logic [7:0] c;
    case (j)
      2'd0:    c = 8'h4F; // O
      2'd1:    c = 8'h4B; // K
      2'd2:    c = 8'h0D;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] connect_char(logic [IDX_W-1:0] j);
    logic [7:0] c;
    case (j)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h4F; // O
      4'd2:    c = 8'h4E; // N
      4'd3:    c = 8'h4E; // N
      4'd4:    c = 8'h45; // E
      4'd5:    c = 8'h43; // C
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h0D;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/megd_if.sv =====
// Input request channel
interface megd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [15:0] elapsed_us;

  modport source (output valid, func, data_byte, elapsed_us, input ready);
  modport sink   (input valid, func, data_byte, elapsed_us, output ready);
endinterface

// Result channel
interface megd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] dest;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, dest, out_byte, last, input ready);
  modport sink   (input valid, dest, out_byte, last, output ready);
endinterface

// Guard time register write channel
interface megd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] guard_units;

  modport source (output valid, guard_units, input ready);
  modport sink   (input valid, guard_units, output ready);
endinterface

// ===== rtl/modem_escape_guard_detector_top.sv =====
// Modem escape guard detector.
// in_chan carries requests: tick (elapsed_us), terminal byte, modem byte or
// return to data mode. out_chan carries result bytes with a destination and
// a last flag on the final result of each request that has results.
// cfg_chan writes the guard time in 20 ms units and is always ready; the
// user must write it only while idle, which the block does not enforce.
// The front classifies one request per cycle while the queue has room and
// updates the escape state; the back expands each job from a four-entry
// queue into its results, one per cycle unless out_chan stalls, through a
// registered output stage. A request passes the queue and the job register
// before its first result is registered there. Single-result requests flow
// at one per cycle; a request with k results (k up to 9 for CONNECT CR LF)
// holds the back until all are sent, so sustained rate is set by the back.
// Reset: data mode, escape progress and quiet timer cleared, guard time 50
// units, queue and output emptied. When out_chan stalls the result is held,
// the back stops, the queue fills and in_chan.ready drops once it is full.
module modem_escape_guard_detector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  megd_in_if.sink     in_chan,
  megd_out_if.source  out_chan,
  megd_cfg_if.sink    cfg_chan
);
  import megd_pkg::*;

  logic push;
  job_t push_job;
  logic fifo_full;
  logic pop;
  logic nonempty;
  job_t head;

  megd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .cfg_chan    (cfg_chan),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  megd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  megd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nonempty_i (nonempty),
    .head_i     (head),
    .pop_o      (pop),
    .out_chan   (out_chan)
  );

endmodule

// ===== rtl/megd_front.sv =====
module megd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  megd_in_if.sink         in_chan,
  megd_cfg_if.sink        cfg_chan,
  input  logic            fifo_full_i,
  output logic            push_o,
  output megd_pkg::job_t  push_job_o
);
  import megd_pkg::*;

  typedef enum logic [2:0] {
    P_WAIT_PAUSE,
    P_WAIT_PLUS1,
    P_WAIT_PLUS2,
    P_WAIT_PLUS3,
    P_WAIT_GUARD
  } prog_e;

  logic               data_mode_q, data_mode_d;
  prog_e              prog_q, prog_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [GUARD_W-1:0] guard_q;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] sat;
  logic               accept;
  logic               push;
  job_t               job;

  assign in_chan.ready  = !fifo_full_i;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;

  // Saturating quiet timer sum
  assign sum = {1'b0, timer_q} + (TIMER_W + 1)'(in_chan.elapsed_us);
  assign sat = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];

  // Classify the request, update escape state and build the job
  always_comb begin
    data_mode_d   = data_mode_q;
    prog_d        = prog_q;
    timer_d       = timer_q;
    push          = 1'b0;
    job.plus_cnt  = 2'd0;
    job.msg       = MSG_NONE;
    job.dest      = DEST_TERM;
    job.data      = in_chan.data_byte;
    case (in_chan.func)
      FUNC_TICK: begin
        timer_d = sat;
        if (data_mode_q && (sat > TIMER_W'(guard_q))) begin
          case (prog_q)
            P_WAIT_PLUS1: ;
            P_WAIT_PLUS2: begin
              prog_d       = P_WAIT_PAUSE;
              timer_d      = '0;
              push         = 1'b1;
              job.plus_cnt = 2'd1;
            end
            P_WAIT_PLUS3: begin
              prog_d       = P_WAIT_PAUSE;
              timer_d      = '0;
              push         = 1'b1;
              job.plus_cnt = 2'd2;
            end
            P_WAIT_GUARD: begin
              data_mode_d = 1'b0;
              prog_d      = P_WAIT_PAUSE;
              timer_d     = '0;
              push        = 1'b1;
              job.msg     = MSG_OK;
            end
            default: begin
              prog_d  = P_WAIT_PLUS1;
              timer_d = '0;
            end
          endcase
        end
      end
      FUNC_TERM: begin
        if (!data_mode_q) begin
          push     = 1'b1;
          job.msg  = MSG_BYTE;
          job.dest = DEST_CLI;
        end else if ((prog_q inside {P_WAIT_PLUS1, P_WAIT_PLUS2, P_WAIT_PLUS3})
                     && (in_chan.data_byte == PLUS_CHAR)) begin
          // Hold the '+' back and advance
          timer_d = '0;
          case (prog_q)
            P_WAIT_PLUS1: prog_d = P_WAIT_PLUS2;
            P_WAIT_PLUS2: prog_d = P_WAIT_PLUS3;
            default:      prog_d = P_WAIT_GUARD;
          endcase
        end else begin
          // Break the sequence: replay held '+' then pass the byte
          case (prog_q)
            P_WAIT_PLUS2: job.plus_cnt = 2'd1;
            P_WAIT_PLUS3: job.plus_cnt = 2'd2;
            P_WAIT_GUARD: job.plus_cnt = 2'd3;
            default:      job.plus_cnt = 2'd0;
          endcase
          prog_d   = P_WAIT_PAUSE;
          timer_d  = '0;
          push     = 1'b1;
          job.msg  = MSG_BYTE;
          job.dest = DEST_MODEM;
        end
      end
      FUNC_MODEM: begin
        if (data_mode_q) begin
          push     = 1'b1;
          job.msg  = MSG_BYTE;
          job.dest = DEST_TERM;
        end
      end
      default: begin
        data_mode_d = 1'b1;
        prog_d      = P_WAIT_PAUSE;
        timer_d     = '0;
        push        = 1'b1;
        job.msg     = MSG_CONNECT;
      end
    endcase
  end

  assign push_o     = accept && push;
  assign push_job_o = job;

  // Hold escape state and guard time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mode_q <= 1'b1;
      prog_q      <= P_WAIT_PAUSE;
      timer_q     <= '0;
      guard_q     <= GUARD_RESET_US;
    end else begin
      if (accept) begin
        data_mode_q <= data_mode_d;
        prog_q      <= prog_d;
        timer_q     <= timer_d;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        guard_q <= GUARD_W'(cfg_chan.guard_units) * US_PER_UNIT_C;
      end
    end
  end

endmodule

// ===== rtl/megd_fifo.sv =====
module megd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  megd_pkg::job_t  push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nonempty_o,
  output megd_pkg::job_t  head_o
);
  import megd_pkg::*;

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(FIFO_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Store queued jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/megd_back.sv =====
module megd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            nonempty_i,
  input  megd_pkg::job_t  head_i,
  output logic            pop_o,
  megd_out_if.source      out_chan
);
  import megd_pkg::*;

  job_t             job_q, job_d;
  logic             job_valid_q, job_valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       dest_q, dest_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             advance;
  logic [IDX_W-1:0] total;
  logic [IDX_W-1:0] msg_idx;
  logic             cur_last;
  logic             load;

  assign advance  = !out_valid_q || out_chan.ready;
  assign total    = IDX_W'(job_q.plus_cnt) + msg_len(job_q.msg);
  assign msg_idx  = idx_q - IDX_W'(job_q.plus_cnt);
  assign cur_last = (idx_q == total - 1'b1);
  assign load     = nonempty_i && (!job_valid_q || (advance && cur_last));
  assign pop_o    = load;

  // Expand the current job one result at a time
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    dest_d      = dest_q;
    byte_d      = byte_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = job_valid_q;
      last_d      = cur_last;
      if (idx_q < IDX_W'(job_q.plus_cnt)) begin
        dest_d = DEST_MODEM;
        byte_d = PLUS_CHAR;
      end else begin
        case (job_q.msg)
          MSG_OK: begin
            dest_d = DEST_TERM;
            byte_d = ok_char(msg_idx[1:0]);
          end
          MSG_CONNECT: begin
            dest_d = DEST_TERM;
            byte_d = connect_char(msg_idx);
          end
          default: begin
            dest_d = job_q.dest;
            byte_d = job_q.data;
          end
        endcase
      end
      if (job_valid_q && !cur_last) begin
        idx_d = idx_q + 1'b1;
      end
    end
    // Take the next job from the queue once the current one is done
    if (load) begin
      job_d       = head_i;
      job_valid_d = 1'b1;
      idx_d       = '0;
    end else if (advance && job_valid_q && cur_last) begin
      job_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    dest_q <= dest_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_chan.valid    = out_valid_q;
  assign out_chan.dest     = dest_q;
  assign out_chan.out_byte = byte_q;
  assign out_chan.last     = last_q;

endmodule

// ===== rtl/megd_checker.sv =====
`include "modem_escape_guard_detector_top_assert.svh"

module megd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] out_dest_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i
);
  import megd_pkg::*;

  // Stalled result stays presented and unchanged
  `MEGD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `MEGD_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_dest_i) && $stable(out_byte_i) && $stable(out_last_i), "result changed while stalled")

  // A burst continues without a gap until its last result
  `MEGD_ASSERT(a_burst_cont, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i, "gap inside a result burst")

  // Command-line bytes are always single results
  `MEGD_ASSERT_NEVER(a_cli_single, out_valid_i && (out_dest_i == DEST_CLI) && !out_last_i, "command-line byte not last")

endmodule

bind modem_escape_guard_detector_top megd_checker u_megd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_dest_i  (out_chan.dest),
  .out_byte_i  (out_chan.out_byte),
  .out_last_i  (out_chan.last)
);
